[sv/vcsg_pkg.sv]
// ----------------------------------------------------------------------------
// vcsg_pkg
// Shared types and codes of the velocity command safety gate.
// ----------------------------------------------------------------------------
package vcsg_pkg;

  localparam int TwistW = 16;
  localparam int AgeW   = 16;
  localparam int ModeW  = 8;
  localparam int TypeW  = 3;
  localparam int ActW   = 2;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  localparam logic [AgeW-1:0] AgeMax = '1;

  localparam logic [AgeW-1:0] ModeFreshRst  = 16'd1000;
  localparam logic [AgeW-1:0] LimitFreshRst = 16'd1000;
  localparam logic [AgeW-1:0] ArmTimeoutRst = 16'd50000;

  typedef logic signed [TwistW-1:0] twist_t;

  typedef enum logic [TypeW-1:0] {
    REQ_TICK  = 3'd0,
    REQ_MODE  = 3'd1,
    REQ_ARM   = 3'd2,
    REQ_LIMIT = 3'd3,
    REQ_CMD   = 3'd4
  } req_type_t;

  localparam logic [ModeW-1:0] MODE_STOP = 8'd1;
  localparam logic [ModeW-1:0] MODE_AUTO = 8'd3;

  typedef enum logic [ActW-1:0] {
    ACT_PASS  = 2'd0,
    ACT_LIMIT = 2'd1,
    ACT_ZERO  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_MODE_FRESH  = 2'd0,
    REG_LIMIT_FRESH = 2'd1,
    REG_ARM_TIMEOUT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    twist_t  lin_x;
    twist_t  lin_y;
    twist_t  lin_z;
    twist_t  ang_x;
    twist_t  ang_y;
    twist_t  ang_z;
    action_t action;
  } result_t;

endpackage

[sv/vcsg_if.sv]
// ----------------------------------------------------------------------------
// vcsg_req_if / vcsg_rsp_if
// Valid/ready channels for request items and gated command results.
// ----------------------------------------------------------------------------
interface vcsg_req_if;
  logic                               valid;
  logic                               ready;
  logic [vcsg_pkg::TypeW-1:0]         req_type;
  logic [vcsg_pkg::ModeW-1:0]         mode_code;
  logic                               arm_start;
  logic signed [vcsg_pkg::TwistW-1:0] lin_x;
  logic signed [vcsg_pkg::TwistW-1:0] lin_y;
  logic signed [vcsg_pkg::TwistW-1:0] lin_z;
  logic signed [vcsg_pkg::TwistW-1:0] ang_x;
  logic signed [vcsg_pkg::TwistW-1:0] ang_y;
  logic signed [vcsg_pkg::TwistW-1:0] ang_z;

  modport source (
    output valid, req_type, mode_code, arm_start, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, mode_code, arm_start, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z,
    output ready
  );
endinterface

interface vcsg_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [vcsg_pkg::TwistW-1:0] out_lin_x;
  logic signed [vcsg_pkg::TwistW-1:0] out_lin_y;
  logic signed [vcsg_pkg::TwistW-1:0] out_lin_z;
  logic signed [vcsg_pkg::TwistW-1:0] out_ang_x;
  logic signed [vcsg_pkg::TwistW-1:0] out_ang_y;
  logic signed [vcsg_pkg::TwistW-1:0] out_ang_z;
  logic [vcsg_pkg::ActW-1:0]          gate_action;

  modport source (
    output valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z,
           gate_action,
    input  ready
  );
  modport sink (
    input  valid, out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z,
           gate_action,
    output ready
  );
endinterface

[sv/velocity_command_safety_gate_top.sv]
// ----------------------------------------------------------------------------
// velocity_command_safety_gate_top
// Gates six-axis Q3.12 velocity commands on mode, obstacle limit and arm state.
//
//   channel  dir  transfer carries
//   req      in   tick, mode, arm trigger, obstacle limit or velocity command
//   rsp      out  gated twist and gate action, one per velocity command
//   apb      in   three 16-bit threshold registers at 0x0, 0x4, 0x8
//
// one request per cycle while req.ready is high. the single compare-and-select
// stage registers each command result into the result register, or into a
// skid register that holds one result while rsp stalls; req.ready drops only
// when both result register and skid register are full. synchronous reset
// restores thresholds, clears gate state and saturates mode and limit ages.
// ----------------------------------------------------------------------------
module velocity_command_safety_gate_top (
  input  logic                        clk,
  input  logic                        rst,
  vcsg_req_if.sink                    req,
  vcsg_rsp_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vcsg_pkg::AddrW-1:0]  paddr,
  input  logic [vcsg_pkg::DataW-1:0]  pwdata,
  output logic [vcsg_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import vcsg_pkg::*;

  logic [AgeW-1:0]  mode_fresh_ticks;
  logic [AgeW-1:0]  limit_fresh_ticks;
  logic [AgeW-1:0]  arm_timeout_ticks;

  logic [ModeW-1:0] mode_reg;
  logic [AgeW-1:0]  mode_age;
  logic             limit_valid;
  logic [AgeW-1:0]  limit_age;
  twist_t           limit_twist [6];
  logic             arm_busy;
  logic [AgeW-1:0]  arm_age;

  result_t          out_res;
  logic             out_valid;
  result_t          skid_res;
  logic             skid_valid;

  logic             in_fire;
  logic             out_fire;
  logic             cmd_fire;
  logic             cfg_wr;
  logic [1:0]       reg_sel;
  logic             mode_fresh;
  logic             is_auto;
  logic             limit_ok;
  logic [TwistW:0]  mag;
  logic             over_limit;
  twist_t           neg_limit;
  result_t          res;
  logic             arm_busy_next;

  // apb
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        REG_MODE_FRESH:  prdata = {{(DataW-AgeW){1'b0}}, mode_fresh_ticks};
        REG_LIMIT_FRESH: prdata = {{(DataW-AgeW){1'b0}}, limit_fresh_ticks};
        REG_ARM_TIMEOUT: prdata = {{(DataW-AgeW){1'b0}}, arm_timeout_ticks};
        default:         prdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_fresh_ticks  <= ModeFreshRst;
      limit_fresh_ticks <= LimitFreshRst;
      arm_timeout_ticks <= ArmTimeoutRst;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      unique case (reg_sel)
        REG_MODE_FRESH:  mode_fresh_ticks  <= pwdata[AgeW-1:0];
        REG_LIMIT_FRESH: limit_fresh_ticks <= pwdata[AgeW-1:0];
        REG_ARM_TIMEOUT: arm_timeout_ticks <= pwdata[AgeW-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign req.ready = !skid_valid;
  assign in_fire   = req.valid && req.ready;
  assign out_fire  = out_valid && rsp.ready;
  assign cmd_fire  = in_fire && (req.req_type == REQ_CMD);

  // gating
  assign mode_fresh = mode_age < mode_fresh_ticks;
  assign is_auto    = mode_reg == MODE_AUTO;
  assign limit_ok   = limit_valid && (limit_age < limit_fresh_ticks);
  assign mag        = req.lin_x[TwistW-1] ? (TwistW+1)'(-$signed({req.lin_x[TwistW-1], req.lin_x}))
                                          : {1'b0, req.lin_x};
  assign over_limit = limit_twist[0][TwistW-1] || (mag > {1'b0, limit_twist[0]});
  assign neg_limit  = (limit_twist[0] == {1'b1, {(TwistW-1){1'b0}}})
                      ? {1'b0, {(TwistW-1){1'b1}}} : -limit_twist[0];

  always_comb begin
    res.lin_x     = req.lin_x;
    res.lin_y     = req.lin_y;
    res.lin_z     = req.lin_z;
    res.ang_x     = req.ang_x;
    res.ang_y     = req.ang_y;
    res.ang_z     = req.ang_z;
    res.action    = ACT_PASS;
    arm_busy_next = arm_busy;
    if (mode_fresh) begin
      if (is_auto && limit_ok && over_limit) begin
        res.lin_x  = req.lin_x[TwistW-1] ? neg_limit : limit_twist[0];
        res.lin_y  = limit_twist[1];
        res.lin_z  = limit_twist[2];
        res.ang_x  = limit_twist[3];
        res.ang_y  = limit_twist[4];
        res.ang_z  = limit_twist[5];
        res.action = ACT_LIMIT;
      end
      if ((mode_reg == MODE_STOP) || (is_auto && arm_busy)) begin
        res.lin_x  = '0;
        res.lin_y  = '0;
        res.lin_z  = '0;
        res.ang_x  = '0;
        res.ang_y  = '0;
        res.ang_z  = '0;
        res.action = ACT_ZERO;
      end
      if (is_auto) begin
        if (arm_busy && (arm_age > arm_timeout_ticks)) begin
          arm_busy_next = 1'b0;
        end
      end else begin
        arm_busy_next = 1'b0;
      end
    end
  end

  // gate state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= '0;
      mode_age    <= AgeMax;
      limit_valid <= 1'b0;
      limit_age   <= AgeMax;
      for (int i = 0; i < 6; i++) limit_twist[i] <= '0;
      arm_busy    <= 1'b0;
      arm_age     <= '0;
    end else if (in_fire) begin
      case (req.req_type)
        REQ_TICK: begin
          if (mode_age != AgeMax) mode_age <= mode_age + 1'b1;
          if (limit_age != AgeMax) limit_age <= limit_age + 1'b1;
          if (arm_age != AgeMax) arm_age <= arm_age + 1'b1;
        end
        REQ_MODE: begin
          mode_reg <= req.mode_code;
          mode_age <= '0;
        end
        REQ_ARM: begin
          arm_busy <= req.arm_start;
          if (req.arm_start) arm_age <= '0;
        end
        REQ_LIMIT: begin
          limit_twist[0] <= req.lin_x;
          limit_twist[1] <= req.lin_y;
          limit_twist[2] <= req.lin_z;
          limit_twist[3] <= req.ang_x;
          limit_twist[4] <= req.ang_y;
          limit_twist[5] <= req.ang_z;
          limit_valid    <= 1'b1;
          limit_age      <= '0;
        end
        REQ_CMD: begin
          arm_busy <= arm_busy_next;
        end
        default: ;
      endcase
    end
  end

  // result register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (cmd_fire) begin
      if (!out_valid || out_fire) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.out_lin_x   = out_res.lin_x;
  assign rsp.out_lin_y   = out_res.lin_y;
  assign rsp.out_lin_z   = out_res.lin_z;
  assign rsp.out_ang_x   = out_res.ang_x;
  assign rsp.out_ang_y   = out_res.ang_y;
  assign rsp.out_ang_z   = out_res.ang_z;
  assign rsp.gate_action = out_res.action;

endmodule

[test/velocity_command_safety_gate_top_tb.sv]
// ----------------------------------------------------------------------------
// velocity_command_safety_gate_top_tb
// Self-checking bench for the velocity command safety gate. A clocked driver
// feeds request transfers from a backlog with random gaps, the result side
// stalls at random, and a monitor predicts every gated command from its own
// copy of the gate state and compares each result transfer field by field.
// Threshold registers are programmed over APB between phases while idle and
// read back. Covers stale and fresh modes, limit capping with sign and
// saturation, zeroing by stop or busy arm, arm expiry, unused request types,
// a write to an unmapped register and age saturation from the reset state.
// ----------------------------------------------------------------------------
module velocity_command_safety_gate_top_tb;
  import vcsg_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 190;

  localparam logic [ModeW-1:0]  MODE_MANUAL   = 8'd2;
  localparam logic [ModeW-1:0]  MODE_UNKNOWN  = 8'hff;
  localparam logic              ARM_ROTATE    = 1'b1;
  localparam logic              ARM_STOPPED   = 1'b0;
  localparam logic [TypeW-1:0]  REQ_UNUSED_LO = 3'd5;
  localparam logic [TypeW-1:0]  REQ_UNUSED_HI = 3'd7;
  localparam logic [AddrW-1:0]  BAD_REG_ADDR  = 4'hc;

  typedef struct packed {
    logic [TypeW-1:0] req_type;
    logic [ModeW-1:0] mode_code;
    logic             arm_start;
    twist_t           lin_x;
    twist_t           lin_y;
    twist_t           lin_z;
    twist_t           ang_x;
    twist_t           ang_y;
    twist_t           ang_z;
  } req_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  vcsg_req_if req_ch ();
  vcsg_rsp_if rsp_ch ();

  velocity_command_safety_gate_top dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  req_item_t req_backlog[$];
  result_t   expected_cmds[$];
  int        errors = 0;
  int        cycle_count = 0;
  bit        drv_quiet = 1'b0;
  bit        sink_quiet = 1'b0;
  int        src_gap = 0;
  int        rsp_stall = 0;

  // gate state as seen by the predictor
  int cfg_val[3] = '{1000, 1000, 50000};
  int held_mode = 0;
  int mode_ticks = 65535;
  bit cap_held = 1'b0;
  int cap_ticks = 65535;
  int cap_twist[6] = '{default: 0};
  bit arm_engaged = 1'b0;
  int arm_ticks = 0;

  function automatic int age_step(input int a);
    return (a >= AgeMax) ? a : a + 1;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic twist_t rand_twist();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return twist_t'($urandom);
    endcase
  endfunction

  function automatic req_item_t make_req(input logic [TypeW-1:0] kind,
                                         input logic [ModeW-1:0] code,
                                         input logic start, input twist_t lx);
    req_item_t it;
    it.req_type  = kind;
    it.mode_code = code;
    it.arm_start = start;
    it.lin_x     = lx;
    it.lin_y     = rand_twist();
    it.lin_z     = rand_twist();
    it.ang_x     = rand_twist();
    it.ang_y     = rand_twist();
    it.ang_z     = rand_twist();
    return it;
  endfunction

  task automatic push_req(input logic [TypeW-1:0] kind, input logic [ModeW-1:0] code,
                          input logic start, input twist_t lx);
    req_backlog.push_back(make_req(kind, code, start, lx));
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic track_request(input req_item_t it);
    int      tw[6];
    int      mag;
    bit      neg;
    action_t act;
    result_t res;
    tw[0] = it.lin_x;
    tw[1] = it.lin_y;
    tw[2] = it.lin_z;
    tw[3] = it.ang_x;
    tw[4] = it.ang_y;
    tw[5] = it.ang_z;
    act = ACT_PASS;
    case (it.req_type)
      REQ_TICK: begin
        mode_ticks = age_step(mode_ticks);
        cap_ticks  = age_step(cap_ticks);
        arm_ticks  = age_step(arm_ticks);
      end
      REQ_MODE: begin
        held_mode  = it.mode_code;
        mode_ticks = 0;
      end
      REQ_ARM: begin
        arm_engaged = it.arm_start;
        if (it.arm_start) arm_ticks = 0;
      end
      REQ_LIMIT: begin
        for (int i = 0; i < 6; i++) cap_twist[i] = tw[i];
        cap_held  = 1'b1;
        cap_ticks = 0;
      end
      REQ_CMD: begin
        if (mode_ticks < cfg_val[REG_MODE_FRESH]) begin
          if (held_mode == MODE_AUTO && cap_held && cap_ticks < cfg_val[REG_LIMIT_FRESH]) begin
            mag = (tw[0] < 0) ? -tw[0] : tw[0];
            if (mag > cap_twist[0]) begin
              neg = (tw[0] < 0);
              for (int i = 0; i < 6; i++) tw[i] = cap_twist[i];
              if (neg) tw[0] = (-cap_twist[0] > 32767) ? 32767 : -cap_twist[0];
              act = ACT_LIMIT;
            end
          end
          if (held_mode == MODE_STOP) begin
            tw = '{default: 0};
            act = ACT_ZERO;
          end
          if (held_mode == MODE_AUTO) begin
            if (arm_engaged) begin
              tw = '{default: 0};
              act = ACT_ZERO;
              if (arm_ticks > cfg_val[REG_ARM_TIMEOUT]) arm_engaged = 1'b0;
            end
          end else begin
            arm_engaged = 1'b0;
          end
        end
        res.lin_x  = tw[0][15:0];
        res.lin_y  = tw[1][15:0];
        res.lin_z  = tw[2][15:0];
        res.ang_x  = tw[3][15:0];
        res.ang_y  = tw[4][15:0];
        res.ang_z  = tw[5][15:0];
        res.action = act;
        expected_cmds.push_back(res);
      end
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      src_gap = 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) src_gap = pick_gap(drv_quiet);
      if (src_gap > 0 || req_backlog.size() == 0) begin
        if (src_gap > 0) src_gap--;
        req_ch.valid <= 1'b0;
      end else begin
        req_item_t nxt;
        nxt = req_backlog.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= nxt.req_type;
        req_ch.mode_code <= nxt.mode_code;
        req_ch.arm_start <= nxt.arm_start;
        req_ch.lin_x     <= nxt.lin_x;
        req_ch.lin_y     <= nxt.lin_y;
        req_ch.lin_z     <= nxt.lin_z;
        req_ch.ang_x     <= nxt.ang_x;
        req_ch.ang_y     <= nxt.ang_y;
        req_ch.ang_z     <= nxt.ang_z;
      end
    end
  end

  // result side stalls
  always @(posedge clk) begin
    if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap(sink_quiet);
    end
  end

  // monitor: predict on request transfer, check on result transfer
  req_item_t seen;
  result_t   want;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        seen.req_type  = req_ch.req_type;
        seen.mode_code = req_ch.mode_code;
        seen.arm_start = req_ch.arm_start;
        seen.lin_x     = req_ch.lin_x;
        seen.lin_y     = req_ch.lin_y;
        seen.lin_z     = req_ch.lin_z;
        seen.ang_x     = req_ch.ang_x;
        seen.ang_y     = req_ch.ang_y;
        seen.ang_z     = req_ch.ang_z;
        track_request(seen);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_cmds.size() == 0) begin
          $error("result transfer with no command outstanding");
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("out_lin_x", want.lin_x, rsp_ch.out_lin_x);
          check_field("out_lin_y", want.lin_y, rsp_ch.out_lin_y);
          check_field("out_lin_z", want.lin_z, rsp_ch.out_lin_z);
          check_field("out_ang_x", want.ang_x, rsp_ch.out_ang_x);
          check_field("out_ang_y", want.ang_y, rsp_ch.out_ang_y);
          check_field("out_ang_z", want.ang_z, rsp_ch.out_ang_z);
          check_field("gate_action", want.action, rsp_ch.gate_action);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL velocity_command_safety_gate_top");
      $finish;
    end
  end

  task automatic drain();
    while (req_backlog.size() != 0 || req_ch.valid || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic [AddrW-1:0] addr, input logic wr,
                            input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic readback_regs();
    logic [DataW-1:0] rd;
    reg_idx_t         r;
    r = r.first();
    repeat (3) begin
      apb_access({r, 2'b00}, 1'b0, '0, rd);
      check_field("prdata", cfg_val[r], rd);
      r = r.next();
    end
  endtask

  task automatic set_thresholds(input int mode_fresh, input int cap_fresh, input int arm_limit);
    logic [DataW-1:0] rd;
    apb_access({REG_MODE_FRESH, 2'b00}, 1'b1, mode_fresh, rd);
    cfg_val[REG_MODE_FRESH] = mode_fresh;
    apb_access({REG_LIMIT_FRESH, 2'b00}, 1'b1, cap_fresh, rd);
    cfg_val[REG_LIMIT_FRESH] = cap_fresh;
    apb_access({REG_ARM_TIMEOUT, 2'b00}, 1'b1, arm_limit, rd);
    cfg_val[REG_ARM_TIMEOUT] = arm_limit;
    readback_regs();
  endtask

  task automatic random_traffic(input int count);
    int               made;
    int               pick;
    int               reps;
    bit               counted;
    logic [TypeW-1:0] kind;
    logic [ModeW-1:0] code;
    made = 0;
    while (made < count) begin
      pick    = $urandom_range(0, 99);
      reps    = 1;
      counted = 1'b1;
      kind    = REQ_CMD;
      if (pick < 20) begin
        kind = REQ_TICK;
        reps = $urandom_range(1, 12);
      end else if (pick < 30) begin
        kind = REQ_MODE;
      end else if (pick < 38) begin
        kind = REQ_ARM;
      end else if (pick < 46) begin
        kind = REQ_LIMIT;
      end else if (pick >= 97) begin
        kind    = TypeW'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        counted = 1'b0;
      end
      repeat (reps) begin
        code = ModeW'($urandom);
        if (kind == REQ_MODE && $urandom_range(0, 7) != 0) code = ModeW'($urandom_range(1, 3));
        push_req(kind, code, 1'($urandom_range(0, 1)), rand_twist());
      end
      if (counted) made += reps;
    end
  endtask

  initial begin
    req_item_t        it;
    logic [DataW-1:0] rd;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = '0;
    req_ch.mode_code = '0;
    req_ch.arm_start = 1'b0;
    req_ch.lin_x     = '0;
    req_ch.lin_y     = '0;
    req_ch.lin_z     = '0;
    req_ch.ang_x     = '0;
    req_ch.ang_y     = '0;
    req_ch.ang_z     = '0;
    rsp_ch.ready     = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    readback_regs();

    // stale mode passes, field extremes
    it = make_req(REQ_CMD, '0, ARM_STOPPED, 16'sh7fff);
    {it.lin_y, it.lin_z, it.ang_x, it.ang_y, it.ang_z} = {5{16'sh7fff}};
    req_backlog.push_back(it);
    it = make_req(REQ_CMD, '0, ARM_STOPPED, 16'sh8000);
    {it.lin_y, it.lin_z, it.ang_x, it.ang_y, it.ang_z} = {5{16'sh8000}};
    req_backlog.push_back(it);
    for (int k = REQ_UNUSED_LO; k <= REQ_UNUSED_HI; k++)
      push_req(TypeW'(k), '0, ARM_ROTATE, rand_twist());
    // saturated mode age stays stale after a tick, so the busy arm survives
    push_req(REQ_ARM, '0, ARM_ROTATE, '0);
    push_req(REQ_TICK, '0, ARM_STOPPED, '0);
    push_req(REQ_CMD, '0, ARM_STOPPED, rand_twist());
    push_req(REQ_MODE, MODE_AUTO, ARM_STOPPED, '0);
    push_req(REQ_CMD, '0, ARM_STOPPED, rand_twist());
    // stop zeroes, manual clears the arm
    push_req(REQ_MODE, MODE_STOP, ARM_STOPPED, '0);
    push_req(REQ_CMD, '0, ARM_STOPPED, rand_twist());
    push_req(REQ_ARM, '0, ARM_ROTATE, '0);
    push_req(REQ_MODE, MODE_MANUAL, ARM_STOPPED, '0);
    push_req(REQ_CMD, '0, ARM_STOPPED, rand_twist());
    // auto with busy arm zeroes
    push_req(REQ_MODE, MODE_AUTO, ARM_STOPPED, '0);
    push_req(REQ_ARM, '0, ARM_ROTATE, '0);
    push_req(REQ_CMD, '0, ARM_STOPPED, rand_twist());
    push_req(REQ_ARM, '0, ARM_STOPPED, '0);
    // limit capping, both signs and the equal case
    push_req(REQ_LIMIT, '0, ARM_STOPPED, 16'sh4000);
    push_req(REQ_CMD, '0, ARM_STOPPED, 16'sh5000);
    push_req(REQ_CMD, '0, ARM_STOPPED, -16'sh5000);
    push_req(REQ_CMD, '0, ARM_STOPPED, 16'sh4000);
    push_req(REQ_CMD, '0, ARM_STOPPED, -16'sh4000);
    // most negative limit negates with saturation
    push_req(REQ_LIMIT, '0, ARM_STOPPED, 16'sh8000);
    push_req(REQ_CMD, '0, ARM_STOPPED, -16'sh0001);
    // most negative command magnitude
    push_req(REQ_LIMIT, '0, ARM_STOPPED, 16'sh7fff);
    push_req(REQ_CMD, '0, ARM_STOPPED, 16'sh8000);
    // busy arm zeroes a command at the cap
    push_req(REQ_ARM, '0, ARM_ROTATE, '0);
    push_req(REQ_CMD, '0, ARM_STOPPED, 16'sh7fff);
    push_req(REQ_TICK, '0, ARM_STOPPED, '0);
    push_req(REQ_MODE, MODE_UNKNOWN, ARM_STOPPED, '0);
    push_req(REQ_CMD, '0, ARM_STOPPED, rand_twist());

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: set_thresholds(0, 0, 0);
        1: set_thresholds(AgeMax, AgeMax, AgeMax);
        default: set_thresholds($urandom_range(1, 40), $urandom_range(1, 40),
                                $urandom_range(0, 30));
      endcase
      if (ph == 3) begin
        apb_access(BAD_REG_ADDR, 1'b1, $urandom, rd);
        readback_regs();
      end
      drv_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      random_traffic(PHASE_ITEMS);
    end
    drain();

    if (errors == 0) begin
      $display("PASS velocity_command_safety_gate_top");
    end else begin
      $display("FAIL velocity_command_safety_gate_top");
    end
    $finish;
  end

endmodule

[velocity_command_safety_gate_top.f]
sv/vcsg_pkg.sv
sv/vcsg_if.sv
sv/velocity_command_safety_gate_top.sv
test/velocity_command_safety_gate_top_tb.sv
